>>> hdl/rmd_pkg.sv
// ----------------------------------------------------------------------------
// rmd_pkg
// Types and constants shared by the reply message deframer modules.
// ----------------------------------------------------------------------------
package rmd_pkg;

  // Reply layout selected by the mode register
  localparam logic [1:0] MODE_NORMAL  = 2'd0;
  localparam logic [1:0] MODE_UPDATE  = 2'd1;
  localparam logic [1:0] MODE_MONITOR = 2'd2;
  localparam logic [1:0] MODE_RSVD    = 2'd3;

  // Configuration register indexes
  localparam logic CFG_REPLY_MODE  = 1'b0;
  localparam logic CFG_EXPECTED_ID = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_REPEAT  = 2'd2;

  // Marker byte values
  localparam logic [7:0] SUCCESS_CODE   = 8'd1;
  localparam logic [7:0] MONITOR_MARKER = 8'd2;

  // Byte positions inside the header
  localparam logic [4:0] POS_SUCCESS  = 5'd0;
  localparam logic [4:0] POS_ID_END   = 5'd4;
  localparam logic [4:0] POS_LEN_END  = 5'd8;
  localparam logic [4:0] POS_UPD_FLAG = 5'd9;
  localparam logic [4:0] POS_TS_END   = 5'd17;
  localparam logic [4:0] POS_CLEN_END = 5'd21;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic        en;
    logic        index;
    logic [31:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        success;
    logic        update_flag;
    logic        timestamp_valid;
    logic [63:0] last_update;
    logic [30:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last_of_message;
  } result_t;

endpackage

>>> hdl/rmd_in_stage.sv
// ----------------------------------------------------------------------------
// rmd_in_stage
// Input register: holds one received word until the parser consumes it.
// ----------------------------------------------------------------------------
module rmd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rmd_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              item_valid,
  output rmd_pkg::in_item_t item
);

  logic              valid_r, valid_nxt;
  rmd_pkg::in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

>>> hdl/rmd_parser.sv
// ----------------------------------------------------------------------------
// rmd_parser
// Configuration registers, byte position counter, field accumulators and the
// per-byte decode that yields at most one result for each consumed word.
// ----------------------------------------------------------------------------
module rmd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  rmd_pkg::cfg_write_t cfg,
  input  logic                advance,
  input  rmd_pkg::in_item_t   item,
  output logic                res_valid,
  output rmd_pkg::result_t    res
);

  logic [1:0]  reply_mode_r;
  logic [31:0] expected_id_r;

  rmd_pkg::phase_t phase_r, phase_nxt, phase_e;
  logic [4:0]  pos_r, pos_nxt, pos_e;
  logic [1:0]  mode_r, mode_nxt, mode_e;
  logic [31:0] rid_r, rid_nxt, rid_e, rid_sh;
  logic [31:0] len_r, len_nxt, len_e, len_sh;
  logic [63:0] ts_r, ts_nxt, ts_e, ts_sh;
  logic        succ_r, succ_nxt, succ_e;
  logic        upd_r, upd_nxt, upd_e;
  logic [30:0] rem_r, rem_nxt, rem_e, rem_dec;
  logic        mon;
  logic [7:0]  b;

  logic        hdr_fire;
  logic [31:0] hdr_len;
  logic        hdr_succ;
  logic        hdr_upd;
  logic        hdr_tsv;
  logic [63:0] hdr_ts;
  logic [31:0] len_clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_mode_r  <= rmd_pkg::MODE_NORMAL;
      expected_id_r <= '0;
    end else if (cfg.en) begin
      case (cfg.index)
        rmd_pkg::CFG_REPLY_MODE: begin
          reply_mode_r <= cfg.data[1:0];
        end
        rmd_pkg::CFG_EXPECTED_ID: begin
          expected_id_r <= cfg.data;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    b = item.data_byte;

    // frame start restarts the parse before this byte is decoded
    if (item.frame_start) begin
      phase_e = rmd_pkg::PH_HEADER;
      pos_e   = '0;
      mode_e  = (reply_mode_r == rmd_pkg::MODE_RSVD) ? rmd_pkg::MODE_NORMAL : reply_mode_r;
      rid_e   = '0;
      len_e   = '0;
      ts_e    = '0;
      succ_e  = 1'b0;
      upd_e   = 1'b0;
      rem_e   = '0;
    end else begin
      phase_e = phase_r;
      pos_e   = pos_r;
      mode_e  = mode_r;
      rid_e   = rid_r;
      len_e   = len_r;
      ts_e    = ts_r;
      succ_e  = succ_r;
      upd_e   = upd_r;
      rem_e   = rem_r;
    end

    rid_sh  = {rid_e[23:0], b};
    len_sh  = {len_e[23:0], b};
    ts_sh   = {ts_e[55:0], b};
    rem_dec = rem_e - 31'd1;
    mon     = (mode_e == rmd_pkg::MODE_MONITOR);

    phase_nxt = phase_e;
    pos_nxt   = pos_e;
    mode_nxt  = mode_e;
    rid_nxt   = rid_e;
    len_nxt   = len_e;
    ts_nxt    = ts_e;
    succ_nxt  = succ_e;
    upd_nxt   = upd_e;
    rem_nxt   = rem_e;

    res_valid = 1'b0;
    res       = '0;
    hdr_fire  = 1'b0;
    hdr_len   = '0;
    hdr_succ  = 1'b0;
    hdr_upd   = 1'b0;
    hdr_tsv   = 1'b0;
    hdr_ts    = '0;

    case (phase_e)
      rmd_pkg::PH_PAYLOAD: begin
        res_valid          = 1'b1;
        res.result_kind    = rmd_pkg::KIND_PAYLOAD;
        res.payload_byte   = b;
        rem_nxt            = rem_dec;
        if (rem_dec == '0) begin
          res.last_of_message = 1'b1;
          phase_nxt           = rmd_pkg::PH_IDLE;
        end
      end
      rmd_pkg::PH_HEADER: begin
        pos_nxt = pos_e + 5'd1;
        if (pos_e == rmd_pkg::POS_SUCCESS) begin
          succ_nxt = (b == rmd_pkg::SUCCESS_CODE);
          if (mon && b != rmd_pkg::MONITOR_MARKER) begin
            phase_nxt = rmd_pkg::PH_IDLE;
          end
        end else if (pos_e <= rmd_pkg::POS_ID_END) begin
          if (mon) begin
            // monitor preamble must be zero; drop silently otherwise
            if (b != 8'd0) begin
              phase_nxt = rmd_pkg::PH_IDLE;
            end
          end else begin
            rid_nxt = rid_sh;
            if (pos_e == rmd_pkg::POS_ID_END && rid_sh != expected_id_r) begin
              res_valid           = 1'b1;
              res.result_kind     = rmd_pkg::KIND_REPEAT;
              res.last_of_message = 1'b1;
              phase_nxt           = rmd_pkg::PH_IDLE;
            end
          end
        end else if (pos_e <= rmd_pkg::POS_LEN_END) begin
          len_nxt = len_sh;
          if (pos_e == rmd_pkg::POS_LEN_END &&
              !(mode_e == rmd_pkg::MODE_UPDATE && succ_e)) begin
            hdr_fire = 1'b1;
            hdr_len  = len_sh;
            hdr_succ = mon ? 1'b0 : succ_e;
          end
        end else if (pos_e == rmd_pkg::POS_UPD_FLAG) begin
          upd_nxt = (b != 8'd0);
        end else if (pos_e <= rmd_pkg::POS_TS_END) begin
          ts_nxt = ts_sh;
          if (pos_e == rmd_pkg::POS_TS_END && !upd_e) begin
            len_nxt  = '0;
            hdr_fire = 1'b1;
            hdr_succ = 1'b1;
            hdr_tsv  = 1'b1;
            hdr_ts   = ts_sh;
          end
        end else if (pos_e <= rmd_pkg::POS_CLEN_END) begin
          len_nxt = len_sh;
          if (pos_e == rmd_pkg::POS_CLEN_END) begin
            hdr_fire = 1'b1;
            hdr_len  = len_sh;
            hdr_succ = 1'b1;
            hdr_upd  = 1'b1;
            hdr_tsv  = 1'b1;
            hdr_ts   = ts_e;
          end
        end else begin
          phase_nxt = rmd_pkg::PH_IDLE;
        end
      end
      default: begin
      end
    endcase

    // negative length means an empty payload
    len_clip = hdr_len[31] ? 32'd0 : hdr_len;
    if (hdr_fire) begin
      res_valid           = 1'b1;
      res.result_kind     = rmd_pkg::KIND_HEADER;
      res.success         = hdr_succ;
      res.update_flag     = hdr_upd;
      res.timestamp_valid = hdr_tsv;
      res.last_update     = hdr_ts;
      res.payload_length  = len_clip[30:0];
      if (len_clip == 32'd0) begin
        res.last_of_message = 1'b1;
        phase_nxt           = rmd_pkg::PH_IDLE;
      end else begin
        rem_nxt   = len_clip[30:0];
        phase_nxt = rmd_pkg::PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rmd_pkg::PH_IDLE;
      pos_r   <= '0;
      mode_r  <= rmd_pkg::MODE_NORMAL;
      rid_r   <= '0;
      len_r   <= '0;
      ts_r    <= '0;
      succ_r  <= 1'b0;
      upd_r   <= 1'b0;
      rem_r   <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      mode_r  <= mode_nxt;
      rid_r   <= rid_nxt;
      len_r   <= len_nxt;
      ts_r    <= ts_nxt;
      succ_r  <= succ_nxt;
      upd_r   <= upd_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

>>> hdl/rmd_out_stage.sv
// ----------------------------------------------------------------------------
// rmd_out_stage
// Result register: holds a result until the consumer takes it.
// ----------------------------------------------------------------------------
module rmd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  logic             res_valid,
  input  rmd_pkg::result_t res,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_ready,
  output rmd_pkg::result_t out_res
);

  logic             valid_r, valid_nxt;
  rmd_pkg::result_t res_r;

  // consume the held word whenever the result slot is free or draining
  assign advance   = item_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = res_valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

endmodule

>>> hdl/reply_message_deframer.sv
// ----------------------------------------------------------------------------
// reply_message_deframer
// Parses reply messages one byte per word into header, payload and repeat results.
// ----------------------------------------------------------------------------
// Takes bytes and gives at most one result per byte; the byte is held in the
// input register and its result in the result register. Each header byte
// advances a position counter and may shift into the id, length or timestamp
// accumulator; throughput is one byte per clock while out_ready stays high.
// Write reply_mode and expected_request_id only while no message is in flight;
// the mode is sampled at each frame_start byte.
// ----------------------------------------------------------------------------
module reply_message_deframer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_kind,
  output logic               out_success,
  output logic               out_update_flag,
  output logic               out_timestamp_valid,
  output logic signed [63:0] out_last_update,
  output logic [30:0]        out_payload_length,
  output logic [7:0]         out_payload_byte,
  output logic               out_last_of_message,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);

  rmd_pkg::in_item_t   in_item;
  rmd_pkg::in_item_t   item;
  rmd_pkg::cfg_write_t cfg;
  rmd_pkg::result_t    res;
  rmd_pkg::result_t    out_res;
  logic                item_valid;
  logic                advance;
  logic                res_valid;

  assign in_item.data_byte   = in_data_byte;
  assign in_item.frame_start = in_frame_start;
  assign cfg.en              = cfg_wr_en;
  assign cfg.index           = cfg_index;
  assign cfg.data            = cfg_wdata;

  rmd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  rmd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .advance   (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  rmd_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res_valid  (res_valid),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  assign out_result_kind     = out_res.result_kind;
  assign out_success         = out_res.success;
  assign out_update_flag     = out_res.update_flag;
  assign out_timestamp_valid = out_res.timestamp_valid;
  assign out_last_update     = $signed(out_res.last_update);
  assign out_payload_length  = out_res.payload_length;
  assign out_payload_byte    = out_res.payload_byte;
  assign out_last_of_message = out_res.last_of_message;

endmodule
